// ===== src/internet_checksum_pseudo_header_unit_defines.svh =====
// assertion helpers used by the checker file
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH

// implication in the same cycle, ignored while in reset
`define ICPH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, ignored while in reset
`define ICPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication in the next cycle, checked through reset as well
`define ICPH_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/icph_pkg.sv =====
`timescale 1ns / 1ps

package icph_pkg;

  localparam int SUM_W = 16;

  localparam logic [1:0] KIND_UDP = 2'd1;
  localparam logic [1:0] KIND_TCP = 2'd2;

  localparam logic [SUM_W-1:0] PROTO_UDP = 16'd17;
  localparam logic [SUM_W-1:0] PROTO_TCP = 16'd6;

  localparam int PSEUDO_OFFSET = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] checksum_kind;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] checksum;
  } out_item_t;

  // packet summary handed from the accumulator to the finishing stage
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [7:0]       pend;
    logic             odd;
    logic [1:0]       kind;
  } fin_t;

  // one's complement add with end-around carry
  function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    oc_add = s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
  endfunction

endpackage

// ===== src/icph_stream_if.sv =====
`timescale 1ns / 1ps

interface icph_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/icph_accum.sv =====
`timescale 1ns / 1ps

module icph_accum #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  icph_pkg::in_item_t     in_item,
  output logic                   fin_valid,
  input  logic                   fin_take,
  output icph_pkg::fin_t         fin,
  output logic [COUNT_WIDTH-1:0] fin_count
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                       s1_valid;
  icph_pkg::in_item_t         s1;
  logic                       s1_go;
  logic                       fin_free;

  logic [icph_pkg::SUM_W-1:0] running_sum;
  logic [7:0]                 pending_high;
  logic                       odd_phase;
  logic [COUNT_WIDTH-1:0]     byte_count;
  logic [1:0]                 kind_latched;
  logic                       in_packet;

  logic [icph_pkg::SUM_W-1:0] base_sum, running_sum_next;
  logic [7:0]                 base_pend, pending_high_next;
  logic                       base_odd, odd_phase_next;
  logic [COUNT_WIDTH-1:0]     base_cnt, byte_count_next;
  logic [1:0]                 kind_eff;

  assign fin_free = !fin_valid || fin_take;
  assign s1_go    = s1_valid && (!s1.last_byte || fin_free);
  assign in_ready = !s1_valid || s1_go;

  // a fresh packet starts from cleared state
  always_comb begin
    base_sum  = in_packet ? running_sum : '0;
    base_pend = in_packet ? pending_high : '0;
    base_odd  = in_packet && odd_phase;
    base_cnt  = in_packet ? byte_count : '0;
    kind_eff  = in_packet ? kind_latched : s1.checksum_kind;

    byte_count_next = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + 1'b1;
    if (!base_odd) begin
      running_sum_next  = base_sum;
      pending_high_next = s1.data_byte;
      odd_phase_next    = 1'b1;
    end else begin
      running_sum_next  = icph_pkg::oc_add(base_sum, {base_pend, s1.data_byte});
      pending_high_next = '0;
      odd_phase_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1 <= in_item;
    end
    if (s1_go && s1.last_byte) begin
      fin.sum   <= running_sum_next;
      fin.pend  <= pending_high_next;
      fin.odd   <= odd_phase_next;
      fin.kind  <= kind_eff;
      fin_count <= byte_count_next;
    end
    if (rst) begin
      s1_valid     <= 1'b0;
      fin_valid    <= 1'b0;
      running_sum  <= '0;
      pending_high <= '0;
      odd_phase    <= 1'b0;
      byte_count   <= '0;
      kind_latched <= '0;
      in_packet    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go && s1.last_byte) begin
        fin_valid <= 1'b1;
      end else if (fin_take) begin
        fin_valid <= 1'b0;
      end
      if (s1_go) begin
        if (s1.last_byte) begin
          running_sum  <= '0;
          pending_high <= '0;
          odd_phase    <= 1'b0;
          byte_count   <= '0;
          kind_latched <= '0;
          in_packet    <= 1'b0;
        end else begin
          running_sum  <= running_sum_next;
          pending_high <= pending_high_next;
          odd_phase    <= odd_phase_next;
          byte_count   <= byte_count_next;
          kind_latched <= kind_eff;
          in_packet    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/icph_finish.sv =====
`timescale 1ns / 1ps

module icph_finish #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fin_valid,
  output logic                   fin_take,
  input  icph_pkg::fin_t         fin,
  input  logic [COUNT_WIDTH-1:0] fin_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output icph_pkg::out_item_t    out_item
);

  localparam logic [COUNT_WIDTH-1:0] OFFSET = COUNT_WIDTH'(icph_pkg::PSEUDO_OFFSET);

  logic                       pseudo;
  logic [COUNT_WIDTH-1:0]     len_term;
  logic [31:0]                len32;
  logic [icph_pkg::SUM_W-1:0] pad, proto, len_lo, len_hi;
  logic [icph_pkg::SUM_W+2:0] total;
  logic [icph_pkg::SUM_W:0]   fold1;
  logic [icph_pkg::SUM_W-1:0] fold2;

  assign fin_take = fin_valid && (!out_valid || out_ready);

  // five terms summed wide, then folded twice
  always_comb begin
    pseudo   = (fin.kind == icph_pkg::KIND_UDP) || (fin.kind == icph_pkg::KIND_TCP);
    len_term = (fin_count >= OFFSET) ? fin_count - OFFSET : '0;
    len32    = 32'(len_term);
    pad      = fin.odd ? {fin.pend, 8'h00} : '0;
    proto    = !pseudo ? '0 :
               (fin.kind == icph_pkg::KIND_UDP) ? icph_pkg::PROTO_UDP : icph_pkg::PROTO_TCP;
    len_lo   = pseudo ? len32[15:0] : '0;
    len_hi   = pseudo ? len32[31:16] : '0;
    total    = 19'(fin.sum) + 19'(pad) + 19'(proto) + 19'(len_lo) + 19'(len_hi);
    fold1    = 17'(total[15:0]) + 17'(total[18:16]);
    fold2    = fold1[15:0] + 16'(fold1[16]);
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_item.checksum <= ~fold2;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/internet_checksum_pseudo_header_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                                   item
// byte_in   in   data_byte[7:0] last_byte checksum_kind[1:0]  one packet byte
// sum_out   out  checksum[15:0]                             one per packet
//
// one byte per cycle while the input is not stalled; the end-around add of each byte pair sets it
// after the last byte is taken, its checksum passes from the input register through the
// summary register into the output register, then waits there until taken
// rst is synchronous and clears the packet state and all valid flags
// a stalled output backs up into the summary and input registers; bytes keep
// flowing, and the input stops only when a last byte finds the summary full

module internet_checksum_pseudo_header_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  icph_stream_if.sink   byte_in,
  icph_stream_if.source sum_out
);

  // packet summary between the accumulator and the finishing stage
  logic                   fin_valid;
  logic                   fin_take;
  icph_pkg::fin_t         fin;
  logic [COUNT_WIDTH-1:0] fin_count;

  // input register, pairing of bytes and running sum
  icph_accum #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (byte_in.ready),
    .in_item  (byte_in.payload),
    .fin_valid(fin_valid),
    .fin_take (fin_take),
    .fin      (fin),
    .fin_count(fin_count)
  );

  // pad, pseudo-header terms, fold, complement and the result register
  icph_finish #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .fin_valid(fin_valid),
    .fin_take (fin_take),
    .fin      (fin),
    .fin_count(fin_count),
    .out_valid(sum_out.valid),
    .out_ready(sum_out.ready),
    .out_item (sum_out.payload)
  );

endmodule

// ===== src/icph_checker.sv =====
`timescale 1ns / 1ps
`include "internet_checksum_pseudo_header_unit_defines.svh"

module icph_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] checksum
);

  // a waiting checksum holds until taken
  `ICPH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(checksum), "checksum dropped or changed while stalled")

  // reset leaves no result pending
  `ICPH_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid, "result valid after reset")

  // with the output empty nothing can block the input
  `ICPH_ASSERT_SAME(a_ready_when_empty, !out_valid && !$past(out_valid), in_ready, "input stalled with empty output")

  // a new result only follows an accepted item
  `ICPH_ASSERT_SAME(a_result_cause, $rose(out_valid), $past(in_valid && in_ready, 2) || $past(in_valid && in_ready, 3) || $past(!in_ready, 2), "result without a preceding item")

endmodule

bind internet_checksum_pseudo_header_unit icph_checker u_icph_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (byte_in.valid),
  .in_ready (byte_in.ready),
  .out_valid(sum_out.valid),
  .out_ready(sum_out.ready),
  .checksum (sum_out.payload.checksum)
);
